// ===== design/wnpc_pkg.sv =====
// Shared types, codes and constants of the whole-number prefix codec.
package wnpc_pkg;

    // Default sizes handed to the top level.
    localparam int VALUE_WIDTH_DEF    = 32;
    localparam int POSITION_WIDTH_DEF = 16;

    // Fixed field widths of the channels.
    localparam int CODE_WORD_WIDTH = 62;
    localparam int CODE_LEN_WIDTH  = 6;
    localparam int CAP_WIDTH       = 16;

    // Reset value of the capacity register.
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 16'hFFFF;

    // Depth of the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Command modes.
    localparam logic [1:0] MODE_ENCODE = 2'd0;
    localparam logic [1:0] MODE_DECODE = 2'd1;
    localparam logic [1:0] MODE_REWIND = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SMALL      = 3'd1;
    localparam logic [2:0] ST_NO_SPACE   = 3'd2;
    localparam logic [2:0] ST_INCOMPLETE = 3'd3;
    localparam logic [2:0] ST_OVERFLOW   = 3'd4;

    // Command word.
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
        logic        code_bit;
    } cmd_word_t;

    // Result word.
    typedef struct packed {
        logic [2:0]                 status;
        logic [CODE_WORD_WIDTH-1:0] code_word;
        logic [CODE_LEN_WIDTH-1:0]  code_length;
        logic [31:0]                decoded_value;
    } rsp_word_t;

    // Operation classes found by the front.
    typedef enum logic [1:0] {
        OP_ENCODE,
        OP_SMALL,
        OP_DECODE,
        OP_REWIND
    } op_t;

    // Classified word passed from front to back.
    typedef struct packed {
        op_t                        op;
        logic [CODE_WORD_WIDTH-1:0] code_word;
        logic [CODE_LEN_WIDTH-1:0]  code_length;
        logic                       code_bit;
    } task_t;

endpackage

// ===== design/whole_number_prefix_codec_core.sv =====
// Top level of the whole-number prefix codec: front, queue, back and checks.
// The codec takes one command word per cycle while the queue is not full and
// sustains one result word per cycle while results are taken: mode 0 encodes
// a value of 3 or more into a right-justified codeword, mode 1 feeds one code
// bit to the decoder, which answers only when a number completes or fails,
// mode 2 rewinds both positions and gives no result, and mode 3 is accepted and
// dropped. A word reaches the back through a two-entry queue; the back executes
// one word per cycle while its result register is free or being emptied, since
// each word is one position update and at most one decoder step, and loads its
// result into the output register. The capacity register may be written only
// while the codec is idle and takes effect on the next word.
module whole_number_prefix_codec_core
    import wnpc_pkg::*;
#(
    parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CAP_WIDTH-1:0] cfg_write_data,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_word_t            cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_word_t            rsp
);

    logic  q_full;
    logic  q_push;
    task_t q_push_task;
    logic  task_valid;
    logic  task_pop;
    task_t head_task;

    // Classification and codeword packing.
    wnpc_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .queue_full(q_full),
        .push      (q_push),
        .push_task (q_push_task)
    );

    // Decoupling queue.
    wnpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_task (q_push_task),
        .full      (q_full),
        .pop       (task_pop),
        .task_valid(task_valid),
        .head_task (head_task)
    );

    // Stateful execution and result register.
    wnpc_back #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .task_valid    (task_valid),
        .head_task     (head_task),
        .task_pop      (task_pop),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp)
    );

    // A full queue always has a word for the back.
    a_full_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> task_valid)
        else $error("queue reports full while empty");

    // The back never pops an empty queue.
    a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        task_pop |-> task_valid)
        else $error("back popped an empty queue");

    // A word of the unused mode never enters the queue.
    a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd.mode == MODE_NONE) |-> !q_push)
        else $error("unused mode word was queued");

    // Error results carry no codeword and no number.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_OK) |->
        (rsp.code_length == '0 && rsp.code_word == '0 && rsp.decoded_value == '0))
        else $error("error result carries data");

endmodule

// ===== design/wnpc_front.sv =====
// Front of the codec: accepts command words, classifies them and packs codewords.
module wnpc_front
    import wnpc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_word_t cmd,
    input  logic      queue_full,
    output logic      push,
    output task_t     push_task
);

    localparam int IDX_W = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] v;
    logic [IDX_W-1:0]       top_idx;
    logic                   sbit;
    logic                   small_val;
    logic [6:0]             p7;
    logic [6:0]             s7;
    logic [6:0]             ones_n;
    logic [6:0]             pay_sh;
    logic [6:0]             len7;
    logic [63:0]            ones_field;
    logic [63:0]            flag_field;
    logic [63:0]            low_field;
    logic [63:0]            word;

    assign cmd_ready = !queue_full;

    // Priority encoder on the value and packing of its codeword.
    always_comb
    begin
        v       = cmd.value[VALUE_WIDTH-1:0];
        top_idx = '0;
        for (int i = 1; i < VALUE_WIDTH; i++)
        begin
            if (v[i])
            begin
                top_idx = IDX_W'(i);
            end
        end
        small_val  = (v < VALUE_WIDTH'(3));
        sbit       = (top_idx == '0) ? 1'b0 : v[top_idx - 1'b1];
        p7         = 7'(top_idx);
        s7         = 7'(sbit);
        ones_n     = p7 + s7 - 7'd2;
        pay_sh     = p7 - 7'd1;
        ones_field = ((64'd1 << ones_n) - 64'd1) << (p7 + 7'd1);
        flag_field = 64'(!sbit) << pay_sh;
        low_field  = 64'(v) & ((64'd1 << pay_sh) - 64'd1);
        word       = ones_field | flag_field | low_field;
        len7       = (p7 << 1) + s7 - 7'd1;
    end

    // Mode decoder: a word of the unused mode is accepted and dropped.
    always_comb
    begin
        push_task.code_word   = word[CODE_WORD_WIDTH-1:0];
        push_task.code_length = len7[CODE_LEN_WIDTH-1:0];
        push_task.code_bit    = cmd.code_bit;
        push_task.op          = OP_REWIND;
        push                  = cmd_valid && cmd_ready;
        unique case (cmd.mode)
            MODE_ENCODE: push_task.op = small_val ? OP_SMALL : OP_ENCODE;
            MODE_DECODE: push_task.op = OP_DECODE;
            MODE_REWIND: push_task.op = OP_REWIND;
            default:     push = 1'b0;
        endcase
    end

endmodule

// ===== design/wnpc_queue.sv =====
// Short queue of classified words between the front and the back.
module wnpc_queue
    import wnpc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  task_t push_task,
    output logic  full,
    input  logic  pop,
    output logic  task_valid,
    output task_t head_task
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    task_t            store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign task_valid = (count_reg != '0);
    assign head_task  = store_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && task_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_task;
        end
    end

endmodule

// ===== design/wnpc_back.sv =====
// Back of the codec: positions, capacity check, bit decoder and result register.
module wnpc_back
    import wnpc_pkg::*;
#(
    parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CAP_WIDTH-1:0] cfg_write_data,
    input  logic                 task_valid,
    input  task_t                head_task,
    output logic                 task_pop,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_word_t            rsp
);

    localparam int PW   = POSITION_WIDTH;
    localparam int VW   = VALUE_WIDTH;
    localparam int CMPW = POSITION_WIDTH + 1;

    typedef enum logic [1:0] {
        PH_ONES,
        PH_SBIT,
        PH_LOAD
    } phase_t;

    logic [CAP_WIDTH-1:0] cap_reg;
    logic [CAP_WIDTH-1:0] cap_next;
    logic [PW-1:0]        wp_reg;
    logic [PW-1:0]        wp_next;
    logic [PW-1:0]        rd_reg;
    logic [PW-1:0]        rd_next;
    phase_t               phase_reg;
    phase_t               phase_next;
    logic [5:0]           ones_reg;
    logic [5:0]           ones_next;
    logic                 sflag_reg;
    logic                 sflag_next;
    logic [5:0]           pleft_reg;
    logic [5:0]           pleft_next;
    logic [VW-1:0]        acc_reg;
    logic [VW-1:0]        acc_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    rsp_word_t            rsp_reg;
    rsp_word_t            rsp_next;

    logic [PW-1:0] cap;
    logic [PW-1:0] room_w;
    logic [PW-1:0] rd_room;
    logic [PW-1:0] rd_inc;
    logic [6:0]    need_close;
    logic [6:0]    pl_s;
    logic          b;
    logic          take;
    logic          fail;
    logic          finish;
    logic          restart;
    logic          res_hit;
    rsp_word_t     res;
    logic          fin_sflag;
    logic [VW-1:0] fin_acc;
    logic [6:0]    fin_pl;
    logic          fin_over;
    logic [VW-1:0] fin_value;

    assign cap       = PW'(cap_reg);
    assign b         = head_task.code_bit;
    assign take      = task_valid && (!rsp_valid_reg || rsp_ready);
    assign task_pop  = take;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Space left for writing and reading, and the bits a closing zero needs.
    always_comb
    begin
        room_w     = (wp_reg >= cap) ? '0 : cap - wp_reg;
        rd_room    = cap - rd_reg;
        rd_inc     = rd_reg + 1'b1;
        need_close = 7'(ones_reg) + 7'd2;
        pl_s       = 7'(ones_reg) + 7'(b);
    end

    // Execution of one classified word.
    always_comb
    begin
        cap_next   = cfg_write_en ? cfg_write_data : cap_reg;
        wp_next    = wp_reg;
        rd_next    = rd_reg;
        phase_next = phase_reg;
        ones_next  = ones_reg;
        sflag_next = sflag_reg;
        pleft_next = pleft_reg;
        acc_next   = acc_reg;
        res        = '0;
        res_hit    = 1'b0;
        fail       = 1'b0;
        finish     = 1'b0;
        restart    = 1'b0;
        fin_sflag  = sflag_reg;
        fin_acc    = acc_reg;

        if (take)
        begin
            unique case (head_task.op)
                OP_SMALL:
                begin
                    res_hit    = 1'b1;
                    res.status = ST_SMALL;
                end
                OP_ENCODE:
                begin
                    res_hit = 1'b1;
                    if (CMPW'(room_w) < CMPW'(head_task.code_length))
                    begin
                        wp_next    = cap;
                        res.status = ST_NO_SPACE;
                    end
                    else
                    begin
                        wp_next         = wp_reg + PW'(head_task.code_length);
                        res.status      = ST_OK;
                        res.code_word   = head_task.code_word;
                        res.code_length = head_task.code_length;
                    end
                end
                OP_REWIND:
                begin
                    wp_next = '0;
                    rd_next = '0;
                    restart = 1'b1;
                end
                OP_DECODE:
                begin
                    if (rd_reg >= cap)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_ONES:
                            begin
                                if (b)
                                begin
                                    ones_next = (ones_reg == 6'd63) ? ones_reg
                                                                     : ones_reg + 6'd1;
                                    rd_next   = rd_inc;
                                end
                                else if (CMPW'(rd_room) < CMPW'(need_close))
                                begin
                                    fail = 1'b1;
                                end
                                else
                                begin
                                    rd_next    = rd_inc;
                                    phase_next = PH_SBIT;
                                end
                            end
                            PH_SBIT:
                            begin
                                rd_next    = rd_inc;
                                sflag_next = !b;
                                if (CMPW'(rd_room - 1'b1) < CMPW'(pl_s))
                                begin
                                    fail = 1'b1;
                                end
                                else
                                begin
                                    pleft_next = (pl_s > 7'd63) ? 6'd63 : pl_s[5:0];
                                    acc_next   = '0;
                                    fin_sflag  = !b;
                                    fin_acc    = '0;
                                    if (pl_s == 7'd0)
                                    begin
                                        finish = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_LOAD;
                                    end
                                end
                            end
                            PH_LOAD:
                            begin
                                rd_next    = rd_inc;
                                acc_next   = {acc_reg[VW-2:0], b};
                                pleft_next = (pleft_reg != 6'd0) ? pleft_reg - 6'd1
                                                                 : pleft_reg;
                                fin_acc    = acc_next;
                                if (pleft_next == 6'd0)
                                begin
                                    finish = 1'b1;
                                end
                            end
                            default:
                            begin
                                restart = 1'b1;
                            end
                        endcase
                    end
                end
                default:
                begin
                    restart = 1'b1;
                end
            endcase
        end

        // Assembly of a completed number.
        fin_pl    = 7'(ones_reg) + 7'(!fin_sflag);
        fin_over  = (fin_pl + 7'd2) > 7'(VW);
        fin_value = (VW'({1'b1, fin_sflag}) << fin_pl) | fin_acc;

        if (fail)
        begin
            rd_next    = cap;
            restart    = 1'b1;
            res_hit    = 1'b1;
            res.status = ST_INCOMPLETE;
        end

        if (finish)
        begin
            restart = 1'b1;
            res_hit = 1'b1;
            if (fin_over)
            begin
                res.status = ST_OVERFLOW;
            end
            else
            begin
                res.status        = ST_OK;
                res.decoded_value = 32'(fin_value);
            end
        end

        if (restart)
        begin
            phase_next = PH_ONES;
            ones_next  = '0;
            sflag_next = 1'b0;
            pleft_next = '0;
            acc_next   = '0;
        end

        // Result register: loaded by a new result, emptied when taken.
        rsp_valid_next = res_hit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);
        rsp_next       = res_hit ? res : rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            wp_reg        <= '0;
            rd_reg        <= '0;
            phase_reg     <= PH_ONES;
            ones_reg      <= '0;
            sflag_reg     <= 1'b0;
            pleft_reg     <= '0;
            acc_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            cap_reg       <= cap_next;
            wp_reg        <= wp_next;
            rd_reg        <= rd_next;
            phase_reg     <= phase_next;
            ones_reg      <= ones_next;
            sflag_reg     <= sflag_next;
            pleft_reg     <= pleft_next;
            acc_reg       <= acc_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

// ===== verif/whole_number_prefix_codec_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the whole-number prefix codec core.
module whole_number_prefix_codec_core_tb
    import wnpc_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int POS_W       = POSITION_WIDTH_DEF;
    localparam int VAL_W       = VALUE_WIDTH_DEF;

    // Where the decoder stands inside a codeword.
    typedef enum logic [1:0] {
        DEC_STREAK,
        DEC_SECOND,
        DEC_PAYLOAD
    } dec_phase_t;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_write_en   = 1'b0;
    logic [CAP_WIDTH-1:0] cfg_write_data = '0;
    logic                 cmd_valid      = 1'b0;
    logic                 cmd_ready;
    cmd_word_t            cmd            = '0;
    logic                 rsp_valid;
    logic                 rsp_ready      = 1'b0;
    rsp_word_t            rsp;

    // Codec model state, mirrored at the widths of the block.
    logic [CAP_WIDTH-1:0] cap_setting = CAP_RESET;
    logic [POS_W-1:0]     wr_pos      = '0;
    logic [POS_W-1:0]     rd_pos      = '0;
    dec_phase_t           phase       = DEC_STREAK;
    logic [5:0]           streak_len  = '0;
    logic                 second_flag = 1'b0;
    logic [5:0]           bits_left   = '0;
    logic [VAL_W-1:0]     payload_acc = '0;

    cmd_word_t cmd_backlog[$];
    rsp_word_t results_due[$];
    int        items_queued  = 0;
    int        mismatches    = 0;
    int        cycle_count   = 0;
    int        send_idle_pct = 26;
    int        recv_idle_pct = 77;

    whole_number_prefix_codec_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp)
    );

    always #1 clk = ~clk;

    // Bits left between a position and the end of the capacity.
    function automatic int space_after(input logic [POS_W-1:0] pos);
        int c;
        c = cap_setting[POS_W-1:0];
        return (pos >= c) ? 0 : c - pos;
    endfunction

    // Codeword of a value of 3 or more: a run of ones, a 0, the inverted
    // second bit, then the bits below it, first-sent bit on top.
    function automatic void build_codeword(input logic [VAL_W-1:0] v,
                                           output logic [CODE_WORD_WIDTH-1:0] word,
                                           output int len);
        int          p;
        int          s;
        logic [63:0] w;
        p = 0;
        for (int i = 1; i < VAL_W; i++)
        begin
            if (v[i])
                p = i;
        end
        s   = v[p-1];
        len = 2 * p + s - 1;
        w   = (((64'd1 << (p + s - 2)) - 64'd1) << (p + 1))
            | (64'(s ^ 1) << (p - 1))
            | (64'(v) & ((64'd1 << (p - 1)) - 64'd1));
        word = w[CODE_WORD_WIDTH-1:0];
    endfunction

    function automatic void clear_decoder();
        phase       = DEC_STREAK;
        streak_len  = '0;
        second_flag = 1'b0;
        bits_left   = '0;
        payload_acc = '0;
    endfunction

    // A read past the end parks the read position at the capacity.
    function automatic void read_fail(output rsp_word_t r);
        rd_pos = cap_setting[POS_W-1:0];
        clear_decoder();
        r        = '0;
        r.status = ST_INCOMPLETE;
    endfunction

    // Closes a codeword: the number, or an overflow when it is too wide.
    function automatic void close_number(output rsp_word_t r);
        int          pl;
        logic [63:0] num;
        pl  = streak_len + (second_flag ? 0 : 1);
        num = (64'(2 + second_flag) << pl) | 64'(payload_acc);
        r   = '0;
        if (pl + 2 > VAL_W)
            r.status = ST_OVERFLOW;
        else
        begin
            r.status        = ST_OK;
            r.decoded_value = num[31:0];
        end
        clear_decoder();
    endfunction

    // One decoder step on one code bit.
    function automatic void decode_bit(input logic b, output bit produced,
                                       output rsp_word_t r);
        int pl;
        produced = 1'b0;
        r        = '0;
        if (rd_pos >= cap_setting[POS_W-1:0])
        begin
            read_fail(r);
            produced = 1'b1;
        end
        else if (phase == DEC_STREAK)
        begin
            if (b)
            begin
                if (streak_len < 63)
                    streak_len = streak_len + 6'd1;
                rd_pos = rd_pos + 1'b1;
            end
            else if (space_after(rd_pos) < streak_len + 2)
            begin
                read_fail(r);
                produced = 1'b1;
            end
            else
            begin
                rd_pos = rd_pos + 1'b1;
                phase  = DEC_SECOND;
            end
        end
        else if (phase == DEC_SECOND)
        begin
            rd_pos      = rd_pos + 1'b1;
            second_flag = ~b;
            pl          = streak_len + b;
            if (space_after(rd_pos) < pl)
            begin
                read_fail(r);
                produced = 1'b1;
            end
            else
            begin
                bits_left   = (pl > 63) ? 6'd63 : pl[5:0];
                payload_acc = '0;
                if (bits_left == 0)
                begin
                    close_number(r);
                    produced = 1'b1;
                end
                else
                    phase = DEC_PAYLOAD;
            end
        end
        else
        begin
            rd_pos      = rd_pos + 1'b1;
            payload_acc = {payload_acc[VAL_W-2:0], b};
            if (bits_left > 0)
                bits_left = bits_left - 6'd1;
            if (bits_left == 0)
            begin
                close_number(r);
                produced = 1'b1;
            end
        end
    endfunction

    // Predicts the result word, if any, of one accepted command word.
    function automatic void codec_step(input cmd_word_t c, output bit produced,
                                       output rsp_word_t r);
        logic [CODE_WORD_WIDTH-1:0] word;
        int                         len;
        produced = 1'b0;
        r        = '0;
        case (c.mode)
            MODE_ENCODE:
            begin
                produced = 1'b1;
                if (c.value < 3)
                    r.status = ST_SMALL;
                else
                begin
                    build_codeword(c.value, word, len);
                    if (space_after(wr_pos) < len)
                    begin
                        wr_pos   = cap_setting[POS_W-1:0];
                        r.status = ST_NO_SPACE;
                    end
                    else
                    begin
                        wr_pos        = wr_pos + POS_W'(len);
                        r.status      = ST_OK;
                        r.code_word   = word;
                        r.code_length = CODE_LEN_WIDTH'(len);
                    end
                end
            end
            MODE_DECODE:
                decode_bit(c.code_bit, produced, r);
            MODE_REWIND:
            begin
                wr_pos = '0;
                rd_pos = '0;
                clear_decoder();
            end
            default:
            begin
            end
        endcase
    endfunction

    // Stimulus helpers; fields that the mode ignores carry random noise.
    task automatic queue_cmd(input logic [1:0] m, input logic [31:0] v, input logic b);
        cmd_word_t c;
        c.mode     = m;
        c.value    = v;
        c.code_bit = b;
        cmd_backlog.push_back(c);
        if (m != MODE_NONE)
            items_queued++;
    endtask

    task automatic queue_encode(input logic [31:0] v);
        queue_cmd(MODE_ENCODE, v, 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_bit(input logic b);
        queue_cmd(MODE_DECODE, $urandom, b);
    endtask

    task automatic queue_rewind();
        queue_cmd(MODE_REWIND, $urandom, 1'($urandom_range(0, 1)));
    endtask

    // Feeds a codeword to the decoder, with an occasional flipped bit.
    task automatic queue_codeword_bits(input logic [31:0] v, input int flip_pct);
        logic [CODE_WORD_WIDTH-1:0] word;
        int                         len;
        logic                       b;
        build_codeword(v, word, len);
        for (int i = len - 1; i >= 0; i--)
        begin
            b = word[i];
            if ($urandom_range(0, 99) < flip_pct)
                b = ~b;
            queue_bit(b);
        end
    endtask

    // Mostly narrow values so that codewords stay short.
    function automatic logic [31:0] pick_value();
        int          w;
        logic [31:0] v;
        w = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 12) : $urandom_range(2, 32);
        v = $urandom;
        if (w < 32)
            v = v & ((32'd1 << w) - 32'd1);
        return v;
    endfunction

    task automatic random_traffic(input int goal);
        int          stop;
        int          pick;
        int          k;
        int          flip_pct;
        logic [31:0] vals[6];
        stop = items_queued + goal;
        while (items_queued < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // Encode a batch, usually rewind, then decode the same codewords.
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                begin
                    vals[i] = pick_value();
                    queue_encode(vals[i]);
                end
                if ($urandom_range(0, 9) != 0)
                    queue_rewind();
                flip_pct = ($urandom_range(0, 4) == 0) ? 3 : 0;
                for (int i = 0; i < k; i++)
                begin
                    if (vals[i] >= 3)
                        queue_codeword_bits(vals[i], flip_pct);
                end
            end
            else if (pick < 55)
            begin
                // Long run of ones: overflow and counter saturation.
                k = $urandom_range(26, 72);
                for (int i = 0; i < k; i++)
                    queue_bit(1'b1);
                queue_bit(1'b0);
                k = $urandom_range(0, 70);
                for (int i = 0; i < k; i++)
                    queue_bit(1'($urandom_range(0, 1)));
            end
            else if (pick < 70)
                queue_encode(pick_value());
            else if (pick < 80)
            begin
                k = $urandom_range(1, 12);
                for (int i = 0; i < k; i++)
                    queue_bit(1'($urandom_range(0, 1)));
            end
            else if (pick < 87)
                queue_rewind();
            else if (pick < 93)
                queue_cmd(MODE_NONE, $urandom, 1'($urandom_range(0, 1)));
            else
                queue_encode($urandom_range(0, 2));
        end
    endtask

    // Waits until every word is through and nothing is left in flight.
    task automatic settle_codec();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_valid || results_due.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_WIDTH-1:0] v);
        settle_codec();
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        cap_setting     = v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        cfg_write_data <= CAP_WIDTH'($urandom);
        @(negedge clk);
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %h, got %h", field, want, got);
        end
    endtask

    // Command driver: presents queued words and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin : drive_cmd
        bit        produced;
        rsp_word_t due;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                codec_step(cmd, produced, due);
                if (produced)
                    results_due.push_back(due);
            end
            if (!cmd_valid || cmd_ready)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cmd       <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : check_rsp
        rsp_word_t due;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result word with none expected: %h", rsp);
                end
                else
                begin
                    due = results_due.pop_front();
                    check_field("status", due.status, rsp.status);
                    check_field("code_word", due.code_word, rsp.code_word);
                    check_field("code_length", due.code_length, rsp.code_length);
                    check_field("decoded_value", due.decoded_value, rsp.decoded_value);
                end
            end
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("whole_number_prefix_codec_core_tb: FAIL");
            $finish;
        end
    end

    // Test sequence: directed words, then random traffic over several capacities.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 77;
        write_capacity(CAP_RESET);

        // Small values, shortest and longest codewords, the ignored mode.
        queue_encode(32'd0);
        queue_encode(32'd1);
        queue_encode(32'd2);
        queue_encode(32'd3);
        queue_encode(32'd4);
        queue_encode(32'd5);
        queue_encode(32'd6);
        queue_encode(32'd7);
        queue_encode(32'h8000_0000);
        queue_encode(32'hFFFF_FFFF);
        queue_cmd(MODE_NONE, 32'hFFFF_FFFF, 1'b1);
        queue_rewind();
        queue_codeword_bits(32'd3, 0);
        queue_codeword_bits(32'd4, 0);
        queue_codeword_bits(32'd7, 0);
        random_traffic(300);

        write_capacity(CAP_WIDTH'($urandom_range(8, 80)));
        random_traffic(330);

        send_idle_pct = 77;
        recv_idle_pct = 26;
        write_capacity('0);
        random_traffic(150);

        write_capacity(CAP_WIDTH'($urandom_range(100, 1000)));
        random_traffic(330);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(16'hFFFF);
        random_traffic(330);

        write_capacity(16'd3);
        random_traffic(300);

        settle_codec();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("whole_number_prefix_codec_core_tb: PASS");
        else
            $display("whole_number_prefix_codec_core_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/wnpc_pkg.sv
design/wnpc_front.sv
design/wnpc_queue.sv
design/wnpc_back.sv
design/whole_number_prefix_codec_core.sv
verif/whole_number_prefix_codec_core_tb.sv
